### hw/rtl/assert_macros.svh
// Assertion helpers for the slot allocator.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define BSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never hold outside reset
`define BSA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

### hw/rtl/bsa_pkg.sv
// Shared constants, codes and types of the bitmap slot allocator.
// No dependencies; bsa_ffs and the allocator use scoped names.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int WORD_BITS   = 64;
    localparam int NUM_WORDS   = MAX_SLOTS / WORD_BITS;
    localparam int STORE_SLOTS = NUM_WORDS * WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int WCNT_W      = $clog2(NUM_WORDS + 1);
    localparam int OFF_W       = $clog2(WORD_BITS);

    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;
    localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

    localparam int IN_TDATA_W  = ((SLOT_W + 1 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + 1 + 7) / 8) * 8;

    // Config port
    localparam int CFG_ADDR_W     = 3;
    localparam int REG_SLOT_COUNT = 0;

    // First-set finder: group stage, then bit-in-group stage
    localparam int FFS_GRP_W  = 8;
    localparam int FFS_GRPS   = WORD_BITS / FFS_GRP_W;
    localparam int FFS_GSEL_W = $clog2(FFS_GRPS);
    localparam int FFS_BSEL_W = $clog2(FFS_GRP_W);

    typedef enum logic [1:0] {
        FN_FIND  = 2'd0,
        FN_READ  = 2'd1,
        FN_WRITE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ENC,
        S_ACCESS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [WORD_BITS-1:0] vec;
    } ffs_req_t;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] bit_idx;
    } ffs_rsp_t;

endpackage

### hw/rtl/bsa_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; used for the occupancy bitmap.
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bsa_ffs.sv
// Two-stage find-first-set over one bitmap word.
// Depends on bsa_pkg; done is registered with the index.
`timescale 1ns / 1ps

module bsa_ffs (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsa_pkg::ffs_req_t req,
    output bsa_pkg::ffs_rsp_t rsp
);

    logic [bsa_pkg::FFS_GSEL_W-1:0] grp_sel;
    logic [bsa_pkg::FFS_GRP_W-1:0]  grp_bits;
    logic [bsa_pkg::FFS_BSEL_W-1:0] bit_sel;

    logic [bsa_pkg::FFS_GSEL_W-1:0] grp_reg;
    logic [bsa_pkg::FFS_GRP_W-1:0]  bits_reg;
    logic                           s1_vld_reg;
    logic [bsa_pkg::OFF_W-1:0]      idx_reg;
    logic                           done_reg;

    // lowest group with a set bit
    always_comb begin
        grp_sel = '0;
        for (int i = bsa_pkg::FFS_GRPS - 1; i >= 0; i--) begin
            if (|req.vec[i*bsa_pkg::FFS_GRP_W +: bsa_pkg::FFS_GRP_W]) begin
                grp_sel = bsa_pkg::FFS_GSEL_W'(i);
            end
        end
        grp_bits = req.vec[grp_sel*bsa_pkg::FFS_GRP_W +: bsa_pkg::FFS_GRP_W];
    end

    always_comb begin
        bit_sel = '0;
        for (int i = bsa_pkg::FFS_GRP_W - 1; i >= 0; i--) begin
            if (bits_reg[i]) begin
                bit_sel = bsa_pkg::FFS_BSEL_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            s1_vld_reg <= req.start;
            done_reg   <= s1_vld_reg;
        end
        if (req.start) begin
            grp_reg  <= grp_sel;
            bits_reg <= grp_bits;
        end
        if (s1_vld_reg) begin
            idx_reg <= {grp_reg, bit_sel};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.bit_idx = idx_reg;

endmodule

### hw/rtl/bitmap_slot_allocator.sv
// Bitmap slot allocator: request FSM, occupancy RAM and first-set finder.
// Depends on bsa_pkg, bsa_ram, bsa_ffs and assert_macros.svh.
//
// Usage:
//  - Request channel s_*: s_tuser carries the function (find, read, write),
//    s_tdata the slot index and the set value. One result per request on m_*.
//  - Results: m_tuser carries the status, m_tdata the found slot and bit.
//  - The user writes slot_count over the APB port only while no request
//    is in flight; the block does not enforce it. One request at a time;
//    s_tready is low from acceptance until the result has moved to the
//    output register; s_tready rises with m_tvalid.
//  - An out-of-range read or write or the unused function goes straight
//    to the done state; a read or write passes the access state; a find
//    reads up to W = min(slot_count, 1024) / 64 words (16 at full size),
//    one word read per cycle, then the two-stage first-set finder.
//  - Reset clears the bitmap through per-word valid bits (no sweep) and
//    sets slot_count to 1024.
//  - A stalled receiver holds the result in the output register; a second
//    result waits in the done state until the output register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_slot_allocator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request: tdata [9:0] slot_index, [10] set_value; tuser [1:0] func
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bsa_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [1:0]                          s_tuser,
    // result: tdata [9:0] found_slot, [10] bit_value; tuser [1:0] status
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bsa_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                          m_tuser,
    // config
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsa_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam logic [bsa_pkg::CNT_W-1:0] STORE_CNT = bsa_pkg::CNT_W'(bsa_pkg::STORE_SLOTS);

    bsa_pkg::state_t state_reg, state_next;

    logic [bsa_pkg::CNT_W-1:0]      slot_count_reg;
    logic [bsa_pkg::NUM_WORDS-1:0]  valid_reg;
    bsa_pkg::func_t                 req_func_reg, req_func_next;
    logic [bsa_pkg::SLOT_W-1:0]     req_idx_reg, req_idx_next;
    logic                           req_setv_reg, req_setv_next;
    logic [bsa_pkg::WCNT_W-1:0]     iss_reg, iss_next;
    logic                           pend_reg, pend_next;
    logic [bsa_pkg::WORD_IDX_W-1:0] dword_reg, dword_next;
    logic [bsa_pkg::WORD_IDX_W-1:0] fword_reg, fword_next;
    bsa_pkg::status_t               res_status_reg, res_status_next;
    logic [bsa_pkg::SLOT_W-1:0]     res_found_reg, res_found_next;
    logic                           res_bit_reg, res_bit_next;

    logic                           m_valid_reg;
    bsa_pkg::status_t               m_status_reg;
    logic [bsa_pkg::SLOT_W-1:0]     m_found_reg;
    logic                           m_bit_reg;

    logic                           accept;
    logic                           out_free;
    logic                           cfg_wr;
    bsa_pkg::func_t                 in_func;
    logic [bsa_pkg::SLOT_W-1:0]     in_idx;
    logic                           in_setv;
    logic                           in_range;
    logic [bsa_pkg::CNT_W-1:0]      eff_count;
    logic [bsa_pkg::WCNT_W-1:0]     scan_words;
    logic [bsa_pkg::WORD_BITS-1:0]  rd_free;
    logic [bsa_pkg::WORD_BITS-1:0]  cur_word;
    logic [bsa_pkg::WORD_BITS-1:0]  bit_mask;
    logic [bsa_pkg::WORD_IDX_W-1:0] req_word;

    logic                           ram_en;
    logic                           ram_we;
    logic [bsa_pkg::WORD_IDX_W-1:0] ram_addr;
    logic [bsa_pkg::WORD_BITS-1:0]  ram_wdata;
    logic [bsa_pkg::WORD_BITS-1:0]  ram_rdata;

    bsa_pkg::ffs_req_t              ffs_req;
    bsa_pkg::ffs_rsp_t              ffs_rsp;

    bsa_ram #(
        .WIDTH (bsa_pkg::WORD_BITS),
        .DEPTH (bsa_pkg::NUM_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bsa_ffs u_ffs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ffs_req),
        .rsp     (ffs_rsp)
    );

    // ---- handshake and decode ----
    assign s_tready = (state_reg == bsa_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_func  = bsa_pkg::func_t'(s_tuser);
    assign in_idx   = s_tdata[bsa_pkg::SLOT_W-1:0];
    assign in_setv  = s_tdata[bsa_pkg::SLOT_W];

    assign eff_count  = (slot_count_reg > STORE_CNT) ? STORE_CNT : slot_count_reg;
    assign scan_words = bsa_pkg::WCNT_W'(eff_count >> bsa_pkg::OFF_W);
    assign in_range   = {1'b0, in_idx} < eff_count;

    // never-written words read as all free
    assign rd_free  = valid_reg[dword_reg] ? ~ram_rdata : '1;
    assign req_word = req_idx_reg[bsa_pkg::OFF_W +: bsa_pkg::WORD_IDX_W];
    assign cur_word = valid_reg[req_word] ? ram_rdata : '0;
    assign bit_mask = bsa_pkg::WORD_BITS'(1) << req_idx_reg[bsa_pkg::OFF_W-1:0];

    // ---- config port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == 1'(bsa_pkg::REG_SLOT_COUNT));
    assign prdata = (paddr[2] == 1'(bsa_pkg::REG_SLOT_COUNT)) ? 32'(slot_count_reg) : '0;

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bsa_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_func)
                        bsa_pkg::FN_FIND:  state_next = bsa_pkg::S_SCAN;
                        bsa_pkg::FN_READ,
                        bsa_pkg::FN_WRITE: state_next = in_range ? bsa_pkg::S_ACCESS
                                                                 : bsa_pkg::S_DONE;
                        default:           state_next = bsa_pkg::S_DONE;
                    endcase
                end
            end
            bsa_pkg::S_SCAN: begin
                if (pend_reg && |rd_free) begin
                    state_next = bsa_pkg::S_ENC;
                end else if (iss_reg >= scan_words) begin
                    state_next = bsa_pkg::S_DONE;
                end
            end
            bsa_pkg::S_ENC: begin
                if (ffs_rsp.done) begin
                    state_next = bsa_pkg::S_DONE;
                end
            end
            bsa_pkg::S_ACCESS: state_next = bsa_pkg::S_DONE;
            bsa_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = bsa_pkg::S_IDLE;
                end
            end
            default: state_next = bsa_pkg::S_IDLE;
        endcase
    end

    // ---- datapath controls ----
    always_comb begin
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = req_word;
        ram_wdata       = cur_word;
        ffs_req.start   = 1'b0;
        ffs_req.vec     = rd_free;
        req_func_next   = req_func_reg;
        req_idx_next    = req_idx_reg;
        req_setv_next   = req_setv_reg;
        iss_next        = iss_reg;
        pend_next       = pend_reg;
        dword_next      = dword_reg;
        fword_next      = fword_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_bit_next    = res_bit_reg;
        case (state_reg)
            bsa_pkg::S_IDLE: begin
                if (accept) begin
                    req_func_next   = in_func;
                    req_idx_next    = in_idx;
                    req_setv_next   = in_setv;
                    iss_next        = '0;
                    pend_next       = 1'b0;
                    res_status_next = bsa_pkg::STAT_OK;
                    res_found_next  = '0;
                    res_bit_next    = 1'b0;
                    ram_en          = 1'b1;
                    ram_addr        = in_idx[bsa_pkg::OFF_W +: bsa_pkg::WORD_IDX_W];
                    if ((in_func == bsa_pkg::FN_READ || in_func == bsa_pkg::FN_WRITE)
                        && !in_range) begin
                        res_status_next = bsa_pkg::STAT_RANGE;
                    end
                end
            end
            bsa_pkg::S_SCAN: begin
                // one word issued per cycle, checked the cycle after
                if (pend_reg && |rd_free) begin
                    ffs_req.start = 1'b1;
                    fword_next    = dword_reg;
                    pend_next     = 1'b0;
                end else if (iss_reg < scan_words) begin
                    ram_en     = 1'b1;
                    ram_addr   = iss_reg[bsa_pkg::WORD_IDX_W-1:0];
                    iss_next   = iss_reg + 1'b1;
                    dword_next = iss_reg[bsa_pkg::WORD_IDX_W-1:0];
                    pend_next  = 1'b1;
                end else begin
                    pend_next       = 1'b0;
                    res_status_next = bsa_pkg::STAT_FULL;
                end
            end
            bsa_pkg::S_ENC: begin
                if (ffs_rsp.done) begin
                    res_found_next = bsa_pkg::SLOT_W'({fword_reg, ffs_rsp.bit_idx});
                end
            end
            bsa_pkg::S_ACCESS: begin
                if (req_func_reg == bsa_pkg::FN_READ) begin
                    res_bit_next = |(cur_word & bit_mask);
                end else begin
                    ram_en    = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata = req_setv_reg ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
                end
            end
            bsa_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bsa_pkg::S_IDLE;
            slot_count_reg <= bsa_pkg::SLOT_COUNT_RESET;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (cfg_wr) begin
                slot_count_reg <= pwdata[bsa_pkg::CNT_W-1:0];
            end
            if (ram_we) begin
                valid_reg[ram_addr] <= 1'b1;
            end
            if (state_reg == bsa_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        req_func_reg   <= req_func_next;
        req_idx_reg    <= req_idx_next;
        req_setv_reg   <= req_setv_next;
        iss_reg        <= iss_next;
        dword_reg      <= dword_next;
        fword_reg      <= fword_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_bit_reg    <= res_bit_next;
        if (state_reg == bsa_pkg::S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_found_reg  <= res_found_reg;
            m_bit_reg    <= res_bit_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = bsa_pkg::OUT_TDATA_W'({m_bit_reg, m_found_reg});

    // ---- assertions ----
    `BSA_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request accepted while busy")
    `BSA_NEVER(a_err_payload, m_tvalid && (m_tuser != bsa_pkg::STAT_OK) && (m_tdata != '0), "error result carries data")
    `BSA_ASSERT(a_out_from_done, $rose(m_tvalid) |-> $past(state_reg == bsa_pkg::S_DONE), "result loaded outside done state")
    `BSA_NEVER(a_no_write_in_scan, ram_we && (state_reg == bsa_pkg::S_SCAN || state_reg == bsa_pkg::S_ENC), "bitmap written during find")

endmodule
